@@ design/hsirgb_pkg.sv @@
`default_nettype none

package hsirgb_pkg;

    // Fixed scaling of the converter.
    localparam int IN_MAX          = 4095;
    localparam int PWM_MAX         = 4095;
    localparam int RATIO_FRAC_BITS = 14;
    localparam int UNIT            = 1 << RATIO_FRAC_BITS;

    // Saturation is a Q1.12 fraction, 4096 is 1.0.
    localparam int S_BITS = 12;
    localparam int S_ONE  = 1 << S_BITS;

    // Field widths.
    localparam int HUE_W  = 10;
    localparam int SAT_W  = 12;
    localparam int INT_W  = 12;
    localparam int CH_W   = 12;
    localparam int OUT_CAP = (PWM_MAX < 4095) ? PWM_MAX : 4095;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 4 * CH_W;

    // Ratio table covers one 120-degree sector.
    localparam int TAB_N   = 120;
    localparam int TAB_IW  = 7;
    localparam int RATIO_W = 17;

    // Datapath widths.
    localparam int S12_W  = S_BITS + 1;
    localparam int OPND_W = 18;
    localparam int PROD_W = 32;
    localparam int WL_W   = 14;
    localparam int FL_W   = WL_W + RATIO_FRAC_BITS;
    localparam int FF_W   = 16;
    localparam int V_W    = 24;
    localparam int X_W    = V_W + FF_W;
    localparam int Y_W    = X_W - RATIO_FRAC_BITS;
    localparam int Q_W    = 13;

    // Final divide by 3*IN_MAX done as a reciprocal multiply with one correction step.
    localparam int DIV_K  = 3 * IN_MAX;
    localparam int RCP_SH = Y_W;
    localparam int RCP_M  = (1 << RCP_SH) / DIV_K;
    localparam int RC_W   = Y_W + Q_W;

    // Q30 rotation constants used to build the ratio table.
    localparam longint Q30_ONE   = 64'sd1073741824;
    localparam longint COS1_Q30  = 64'sd1073578288;
    localparam longint SIN1_Q30  = 64'sd18739379;
    localparam longint SQRT3_Q30 = 64'sd1859775393;

    typedef enum logic [1:0] {
        SEC_RG,
        SEC_GB,
        SEC_BR
    } sector_t;

    typedef struct packed {
        logic    mode;
        sector_t sector;
    } side_t;

    // Load enables of the three channel scaling stages.
    typedef struct packed {
        logic mul;
        logic rcp;
        logic fix;
    } chan_en_t;

    // Signed quotient truncated toward zero, by shift and subtract.
    function automatic longint div_trunc(input longint num, input longint den);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        n = (num < 0) ? 64'(-num) : 64'(num);
        d = (den < 0) ? 64'(-den) : 64'(den);
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Ratio cos(t)/cos(60-t) in signed fixed point, evaluated at elaboration.
    function automatic longint ratio_at(input int t);
        longint c;
        longint s;
        longint nc;
        longint ns;
        longint d;
        c = Q30_ONE;
        s = 0;
        for (int i = 0; i < t; i++)
        begin
            nc = div_trunc(c * COS1_Q30 - s * SIN1_Q30, Q30_ONE);
            ns = div_trunc(s * COS1_Q30 + c * SIN1_Q30, Q30_ONE);
            c  = nc;
            s  = ns;
        end
        d = c + div_trunc(SQRT3_Q30 * s, Q30_ONE);
        if (d < 1)
        begin
            d = 1;
        end
        return div_trunc(2 * c * longint'(UNIT), d);
    endfunction

endpackage

`default_nettype wire

@@ design/hsirgb_chan.sv @@
`default_nettype none

module hsirgb_chan (
    input  logic                        clk,
    input  hsirgb_pkg::chan_en_t        en,
    input  logic [hsirgb_pkg::V_W-1:0]  v,
    input  logic [hsirgb_pkg::FF_W-1:0] ff,
    output logic [hsirgb_pkg::CH_W-1:0] q
);
    import hsirgb_pkg::*;

    logic [X_W-1:0]  x_reg;
    logic [X_W-1:0]  x_next;
    logic [Y_W-1:0]  y_reg;
    logic [Y_W-1:0]  y_next;
    logic [Q_W-1:0]  q0_reg;
    logic [Q_W-1:0]  q0_next;
    logic [RC_W-1:0] rc_prod;
    logic [Y_W-1:0]  rem;
    logic [Q_W-1:0]  q1;
    logic [CH_W-1:0] q_reg;
    logic [CH_W-1:0] q_next;

    assign x_next = X_W'(v) * X_W'(ff);

    // The low fraction bits of the ratio scale drop out before the reciprocal step.
    assign y_next  = x_reg[X_W-1:RATIO_FRAC_BITS];
    assign rc_prod = RC_W'(y_next) * RC_W'(RCP_M);
    assign q0_next = rc_prod[RCP_SH +: Q_W];

    // The estimate is low by at most one.
    always_comb
    begin
        rem = y_reg - Y_W'(q0_reg) * Y_W'(DIV_K);
        q1  = q0_reg;
        if (rem >= Y_W'(DIV_K))
        begin
            q1 = q0_reg + Q_W'(1);
        end
        if (q1 > Q_W'(OUT_CAP))
        begin
            q_next = CH_W'(OUT_CAP);
        end
        else
        begin
            q_next = q1[CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            x_reg <= x_next;
        end
        if (en.rcp)
        begin
            y_reg  <= y_next;
            q0_reg <= q0_next;
        end
        if (en.fix)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ design/hsi_to_rgb_rgbw_converter_core.sv @@
`default_nettype none

// Channel  Direction  Handshake                Payload
// cfg      in         cfg_valid / cfg_ready    cfg_data: rgbw_mode
// s        in         s_tvalid / s_tready      s_tdata: hue, saturation, intensity
// m        out        m_tvalid / m_tready      m_tdata: red, green, blue, white
//
// One request per clock cycle while the output is not stalled; each request passes through
// the eight register stages in order (hue reduction, ratio lookup,
// saturation products, factor forming, three stages of channel scaling, and routing).
// Reset clears the stage valid bits and rgbw_mode; data registers are not reset.
// Every stage has its own ready, so a stalled output holds its result while empty
// stages behind it keep filling; nothing is dropped or repeated.
module hsi_to_rgb_rgbw_converter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,   // rgbw_mode
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // hue [9:0], saturation [21:10], intensity [33:22], zeros [39:34]
    input  logic [hsirgb_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red [11:0], green [23:12], blue [35:24], white [47:36]
    output logic [hsirgb_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hsirgb_pkg::*;

    localparam int NSTG = 8;

    logic                      mode_reg;
    logic [NSTG:1]             vld_reg;
    logic [NSTG+1:1]           rdy;
    side_t                     side_reg [1:NSTG];
    side_t                     side_next;

    logic signed [RATIO_W-1:0] ratio_tab [TAB_N];

    // Stage 1
    logic [HUE_W-1:0]          hue_in;
    logic [SAT_W-1:0]          sat_in;
    logic [INT_W-1:0]          int_in;
    logic [HUE_W-2:0]          hmod;
    logic [TAB_IW-1:0]         t1_reg;
    logic [TAB_IW-1:0]         t1_next;
    logic [S12_W-1:0]          s1_reg;
    logic [S12_W-1:0]          s1_next;
    logic [V_W-1:0]            v1_reg;
    logic [V_W-1:0]            v1_next;

    // Stage 2
    logic signed [OPND_W-1:0]  r_ext;
    logic signed [OPND_W-1:0]  unit_s;
    logic signed [OPND_W-1:0]  rd2_reg;
    logic signed [OPND_W-1:0]  rd2_next;
    logic signed [OPND_W-1:0]  rn2_reg;
    logic signed [OPND_W-1:0]  rn2_next;
    logic [S12_W-1:0]          s2_reg;
    logic [S12_W-1:0]          om2_reg;
    logic [S12_W-1:0]          om2_next;
    logic [V_W-1:0]            v2_reg;

    // Stage 3
    logic signed [PROD_W-1:0]  pd3_reg;
    logic signed [PROD_W-1:0]  pd3_next;
    logic signed [PROD_W-1:0]  pn3_reg;
    logic signed [PROD_W-1:0]  pn3_next;
    logic [WL_W-1:0]           wl3_reg;
    logic [WL_W-1:0]           wl3_next;
    logic [V_W-1:0]            v3_reg;

    // Stage 4
    logic signed [PROD_W-1:0]  base;
    logic signed [PROD_W-1:0]  fd;
    logic signed [PROD_W-1:0]  fn;
    logic [FL_W-1:0]           fl;
    logic [FF_W-1:0]           ffd4_reg;
    logic [FF_W-1:0]           ffd4_next;
    logic [FF_W-1:0]           ffn4_reg;
    logic [FF_W-1:0]           ffn4_next;
    logic [FF_W-1:0]           ffl4_reg;
    logic [FF_W-1:0]           ffl4_next;
    logic [V_W-1:0]            v4_reg;

    // Stages 5 to 7 and output
    chan_en_t                  chan_en;
    logic [CH_W-1:0]           qd;
    logic [CH_W-1:0]           qn;
    logic [CH_W-1:0]           ql;
    logic [CH_W-1:0]           red_c;
    logic [CH_W-1:0]           green_c;
    logic [CH_W-1:0]           blue_c;
    logic [CH_W-1:0]           white_c;
    logic [CH_W-1:0]           last_c;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_next;

    for (genvar g = 0; g < TAB_N; g++)
    begin : g_tab
        localparam longint RV = ratio_at(g);
        assign ratio_tab[g] = RATIO_W'(RV);
    end

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Per-stage ready lets bubbles close up under a stalled output.
    always_comb
    begin
        rdy[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: hue reduction, sector split, saturation scale, intensity scale.
    assign hue_in = s_tdata[HUE_W-1:0];
    assign sat_in = s_tdata[HUE_W +: SAT_W];
    assign int_in = s_tdata[HUE_W+SAT_W +: INT_W];

    always_comb
    begin
        if (hue_in >= 10'd720)
        begin
            hmod = 9'(hue_in - 10'd720);
        end
        else if (hue_in >= 10'd360)
        begin
            hmod = 9'(hue_in - 10'd360);
        end
        else
        begin
            hmod = hue_in[HUE_W-2:0];
        end

        side_next.mode = mode_reg;
        if (hmod < 9'd120)
        begin
            side_next.sector = SEC_RG;
            t1_next          = 7'(hmod);
        end
        else if (hmod < 9'd240)
        begin
            side_next.sector = SEC_GB;
            t1_next          = 7'(hmod - 9'd120);
        end
        else
        begin
            side_next.sector = SEC_BR;
            t1_next          = 7'(hmod - 9'd240);
        end
    end

    // With a 12-bit input and full scale 4095, sat*4096/4095 only gains one at full scale.
    assign s1_next = S12_W'(sat_in) + S12_W'(sat_in == SAT_W'(IN_MAX));
    assign v1_next = V_W'(int_in) * V_W'(PWM_MAX);

    // Stage 2: ratio lookup and multiplier operands for the mode.
    assign r_ext  = OPND_W'(ratio_tab[t1_reg]);
    assign unit_s = OPND_W'(UNIT);

    always_comb
    begin
        if (side_reg[1].mode)
        begin
            rd2_next = unit_s + r_ext;
            rn2_next = (unit_s <<< 1) - r_ext;
        end
        else
        begin
            rd2_next = r_ext;
            rn2_next = unit_s - r_ext;
        end
    end

    assign om2_next = S12_W'(S_ONE) - s1_reg;

    // Stage 3: saturation products.
    assign pd3_next = PROD_W'($signed({1'b0, s2_reg})) * PROD_W'(rd2_reg);
    assign pn3_next = PROD_W'($signed({1'b0, s2_reg})) * PROD_W'(rn2_reg);
    assign wl3_next = side_reg[2].mode ? WL_W'(om2_reg) * WL_W'(3) : WL_W'(om2_reg);

    // Stage 4: full factors, negative ones forced to zero, then the saturation fraction bits dropped.
    assign base = side_reg[3].mode ? '0 : PROD_W'(S_ONE) <<< RATIO_FRAC_BITS;
    assign fd   = base + pd3_reg;
    assign fn   = base + pn3_reg;
    assign fl   = FL_W'(wl3_reg) << RATIO_FRAC_BITS;

    assign ffd4_next = fd[PROD_W-1] ? '0 : fd[S_BITS +: FF_W];
    assign ffn4_next = fn[PROD_W-1] ? '0 : fn[S_BITS +: FF_W];
    assign ffl4_next = fl[S_BITS +: FF_W];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            t1_reg <= t1_next;
            s1_reg <= s1_next;
            v1_reg <= v1_next;
            side_reg[1] <= side_next;
        end
        if (rdy[2])
        begin
            rd2_reg <= rd2_next;
            rn2_reg <= rn2_next;
            s2_reg  <= s1_reg;
            om2_reg <= om2_next;
            v2_reg  <= v1_reg;
        end
        if (rdy[3])
        begin
            pd3_reg <= pd3_next;
            pn3_reg <= pn3_next;
            wl3_reg <= wl3_next;
            v3_reg  <= v2_reg;
        end
        if (rdy[4])
        begin
            ffd4_reg <= ffd4_next;
            ffn4_reg <= ffn4_next;
            ffl4_reg <= ffl4_next;
            v4_reg   <= v3_reg;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (rdy[NSTG])
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Stages 5 to 7: channel scaling.
    assign chan_en.mul = rdy[5];
    assign chan_en.rcp = rdy[6];
    assign chan_en.fix = rdy[7];

    hsirgb_chan u_chan_dom (
        .clk (clk),
        .en  (chan_en),
        .v   (v4_reg),
        .ff  (ffd4_reg),
        .q   (qd)
    );

    hsirgb_chan u_chan_nxt (
        .clk (clk),
        .en  (chan_en),
        .v   (v4_reg),
        .ff  (ffn4_reg),
        .q   (qn)
    );

    // Third unit gives the last color in RGB mode and white in RGBW mode.
    hsirgb_chan u_chan_lst (
        .clk (clk),
        .en  (chan_en),
        .v   (v4_reg),
        .ff  (ffl4_reg),
        .q   (ql)
    );

    // Stage 8: route the channels by sector.
    always_comb
    begin
        if (side_reg[7].mode)
        begin
            last_c  = '0;
            white_c = ql;
        end
        else
        begin
            last_c  = ql;
            white_c = '0;
        end

        case (side_reg[7].sector)
            SEC_RG:
            begin
                red_c   = qd;
                green_c = qn;
                blue_c  = last_c;
            end
            SEC_GB:
            begin
                green_c = qd;
                blue_c  = qn;
                red_c   = last_c;
            end
            default:
            begin
                blue_c  = qd;
                red_c   = qn;
                green_c = last_c;
            end
        endcase

        m_tdata_next = {white_c, blue_c, green_c, red_c};
    end

    assign m_tdata = m_tdata_reg;

    // A refused request means every stage holds an item.
    a_full_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg)
    ) else $error("input refused while a stage is empty");

    a_white_rgb: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !side_reg[NSTG].mode) |-> (m_tdata[3*CH_W +: CH_W] == '0)
    ) else $error("white is nonzero in RGB mode");

    a_last_rgbw: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && side_reg[NSTG].mode) |->
            (m_tdata[0 +: CH_W] == '0 || m_tdata[CH_W +: CH_W] == '0 ||
             m_tdata[2*CH_W +: CH_W] == '0)
    ) else $error("no color is zero in RGBW mode");

endmodule

`default_nettype wire

@@ verif/hsi_rgbw_checker.sv @@
`timescale 1ns / 1ps

module hsi_rgbw_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic                               cfg_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [hsirgb_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [hsirgb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                                 mismatches,
    output int                                 pending
);
    import hsirgb_pkg::*;

    typedef struct packed {
        logic [IN_TDATA_W-HUE_W-SAT_W-INT_W-1:0] pad;
        logic [INT_W-1:0]                        intensity;
        logic [SAT_W-1:0]                        saturation;
        logic [HUE_W-1:0]                        hue;
    } hsi_req_t;

    typedef struct packed {
        logic [CH_W-1:0] white;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgbw_levels_t;

    longint       cos_ratio_q[0:TAB_N-1];
    logic         rgbw_on;
    rgbw_levels_t expected_levels[$];

    // Ratio cos(t)/cos(60-t), built by stepping a Q30 rotation one degree at a time.
    initial
    begin
        longint cq;
        longint sq;
        longint den;
        longint nc;
        cq = Q30_ONE;
        sq = 0;
        for (int t = 0; t < TAB_N; t++)
        begin
            den = cq + (SQRT3_Q30 * sq) / Q30_ONE;
            if (den < 1)
            begin
                den = 1;
            end
            cos_ratio_q[t] = (2 * cq * longint'(UNIT)) / den;
            nc = (cq * COS1_Q30 - sq * SIN1_Q30) / Q30_ONE;
            sq = (sq * COS1_Q30 + cq * SIN1_Q30) / Q30_ONE;
            cq = nc;
        end
    end

    initial
    begin
        mismatches = 0;
        pending    = 0;
        rgbw_on    = 1'b0;
    end

    function automatic logic [CH_W-1:0] scale_level(input longint v, input longint f);
        longint q;
        if (f < 0)
        begin
            f = 0;
        end
        q = (v * (f / longint'(S_ONE))) / (3 * longint'(IN_MAX) * longint'(UNIT));
        if (q > OUT_CAP)
        begin
            q = OUT_CAP;
        end
        return q[CH_W-1:0];
    endfunction

    function automatic rgbw_levels_t convert_hsi(input hsi_req_t px, input logic rgbw);
        int unsigned     h;
        longint          sat;
        longint          inten;
        longint          s12;
        longint          v;
        longint          r;
        longint          u;
        logic [CH_W-1:0] dom;
        logic [CH_W-1:0] nxt;
        logic [CH_W-1:0] lst;
        logic [CH_W-1:0] wht;
        sector_t         sec;
        rgbw_levels_t    lv;
        h     = px.hue % 360;
        sat   = (px.saturation > IN_MAX) ? IN_MAX : px.saturation;
        inten = (px.intensity > IN_MAX) ? IN_MAX : px.intensity;
        s12   = (sat * S_ONE) / IN_MAX;
        v     = inten * PWM_MAX;
        u     = UNIT;
        r     = cos_ratio_q[h % 120];
        sec   = (h < 120) ? SEC_RG : (h < 240) ? SEC_GB : SEC_BR;
        if (rgbw)
        begin
            dom = scale_level(v, s12 * (u + r));
            nxt = scale_level(v, s12 * (2 * u - r));
            lst = '0;
            wht = scale_level(v, 3 * (S_ONE - s12) * u);
        end
        else
        begin
            dom = scale_level(v, S_ONE * u + s12 * r);
            nxt = scale_level(v, S_ONE * u + s12 * (u - r));
            lst = scale_level(v, (S_ONE - s12) * u);
            wht = '0;
        end
        case (sec)
            SEC_RG:
            begin
                lv.red = dom; lv.green = nxt; lv.blue = lst;
            end
            SEC_GB:
            begin
                lv.green = dom; lv.blue = nxt; lv.red = lst;
            end
            default:
            begin
                lv.blue = dom; lv.red = nxt; lv.green = lst;
            end
        endcase
        lv.white = wht;
        return lv;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgbw_levels_t got;
        rgbw_levels_t want;
        if (!rst_n)
        begin
            rgbw_on = 1'b0;
            expected_levels.delete();
            pending <= 0;
        end
        else
        begin
            // A request taken together with a mode write still sees the old mode.
            if (s_tvalid && s_tready)
            begin
                expected_levels.push_back(convert_hsi(hsi_req_t'(s_tdata), rgbw_on));
            end
            if (cfg_valid && cfg_ready)
            begin
                rgbw_on = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got = rgbw_levels_t'(m_tdata);
                if (expected_levels.size() == 0)
                begin
                    report_mismatch("result with no request pending", int'(m_tdata[31:0]), 0);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.red != want.red)
                    begin
                        report_mismatch("red", got.red, want.red);
                    end
                    if (got.green != want.green)
                    begin
                        report_mismatch("green", got.green, want.green);
                    end
                    if (got.blue != want.blue)
                    begin
                        report_mismatch("blue", got.blue, want.blue);
                    end
                    if (got.white != want.white)
                    begin
                        report_mismatch("white", got.white, want.white);
                    end
                end
            end
            pending <= expected_levels.size();
        end
    end

endmodule

@@ verif/tb_hsi_to_rgb_rgbw_converter_core.sv @@
`timescale 1ns / 1ps

module tb_hsi_to_rgb_rgbw_converter_core;

    localparam int CYCLE_LIMIT = 200000;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic                               cfg_data;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [hsirgb_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [hsirgb_pkg::OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int cycles;

    hsi_to_rgb_rgbw_converter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hsi_rgbw_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        cycles   = 0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pixel(input logic [9:0] hue, input logic [11:0] sat,
                              input logic [11:0] inten);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, inten, sat, hue};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_mode(input logic rgbw);
        cfg_valid <= 1'b1;
        cfg_data  <= rgbw;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Holds off the source until every outstanding request has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Sector edges, hue wrap, all-zero and all-one fields, alternating bit patterns.
    task automatic run_directed();
        send_pixel(10'd0, 12'd0, 12'd0);
        send_pixel(10'd0, 12'd4095, 12'd4095);
        send_pixel(10'd119, 12'd4095, 12'd4095);
        send_pixel(10'd120, 12'd4095, 12'd4095);
        send_pixel(10'd239, 12'd2048, 12'd4095);
        send_pixel(10'd240, 12'd4095, 12'd4095);
        send_pixel(10'd359, 12'd4095, 12'd4095);
        send_pixel(10'd360, 12'd4095, 12'd4095);
        send_pixel(10'd719, 12'd1000, 12'd3000);
        send_pixel(10'd1023, 12'd4095, 12'd4095);
        send_pixel(10'd682, 12'hAAA, 12'h555);
        send_pixel(10'd341, 12'h555, 12'hAAA);
    endtask

    task automatic run_random(input int count, input bit pause_midway);
        logic [9:0]  hue;
        logic [11:0] sat;
        logic [11:0] inten;
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
            begin
                drain_results();
            end
            case ($urandom_range(0, 9))
                0:       hue = 10'($urandom_range(0, 1023));
                1:       hue = 10'(120 * $urandom_range(0, 5) +
                               ($urandom_range(0, 1) ? 119 : 0));
                default: hue = 10'($urandom_range(0, 719));
            endcase
            case ($urandom_range(0, 7))
                0:       sat = 12'd0;
                1:       sat = 12'd4095;
                default: sat = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
                0:       inten = 12'd4095;
                1:       inten = 12'($urandom_range(0, 15));
                default: inten = 12'($urandom_range(0, 4095));
            endcase
            send_pixel(hue, sat, inten);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_pct = 38;
        rx_idle_pct = 60;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        run_directed();
        drain_results();
        write_mode(1'b1);
        run_directed();
        drain_results();

        write_mode(1'b0);
        run_random(400, 1'b1);
        drain_results();

        tx_idle_pct = 60;
        rx_idle_pct = 38;
        write_mode(1'b1);
        run_random(400, 1'b0);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mode(1'b0);
        run_random(175, 1'b0);
        drain_results();
        write_mode(1'b1);
        run_random(175, 1'b0);
        drain_results();

        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
